// ===== hdl/eif_pkg.sv =====
`default_nettype none
package eif_pkg;

  localparam int SAMPLE_BITS           = 12;
  localparam int COEF_W                = 16;
  localparam int OFFSET_W              = 12;
  localparam int CFG_IDX_W             = 3;
  localparam int DEF_COEF_FRAC_BITS    = 14;
  localparam int DEF_SIGNAL_WIDTH      = 32;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

  // register reset values (Q2.14 coefficients, integer offset)
  localparam logic [COEF_W-1:0]   RST_HP_COEF  = 16'sd16333;
  localparam logic [COEF_W-1:0]   RST_NOTCH_B1 = -16'sd30468;
  localparam logic [COEF_W-1:0]   RST_NOTCH_A1 = -16'sd28554;
  localparam logic [COEF_W-1:0]   RST_NOTCH_A2 = 16'sd14390;
  localparam logic [COEF_W-1:0]   RST_LP_COEF  = 16'sd3293;
  localparam logic [OFFSET_W-1:0] RST_OFFSET   = 12'd2048;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HP_COEF    = 3'd0,
    CFG_NOTCH_B1   = 3'd1,
    CFG_NOTCH_A1   = 3'd2,
    CFG_NOTCH_A2   = 3'd3,
    CFG_LP_COEF    = 3'd4,
    CFG_OUT_OFFSET = 3'd5
  } eif_cfg_idx_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] highpass_coef;
    logic signed [COEF_W-1:0] notch_b1;
    logic signed [COEF_W-1:0] notch_a1;
    logic signed [COEF_W-1:0] notch_a2;
    logic signed [COEF_W-1:0] lowpass_coef;
    logic [OFFSET_W-1:0]      output_offset;
  } eif_cfg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] clean_sample;
    logic                   clipped;
  } eif_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HP_ADD,
    ST_HP_SUB,
    ST_M_HP,
    ST_M_B1,
    ST_ADD_X2,
    ST_M_A1,
    ST_M_A2,
    ST_M_LPA,
    ST_M_LPB,
    ST_OUT
  } eif_state_t;

endpackage
`default_nettype wire

// ===== hdl/eif_stream_if.sv =====
`default_nettype none
interface eif_sample_if;
  logic                            valid;
  logic                            ready;
  logic [eif_pkg::SAMPLE_BITS-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface eif_result_if;
  logic                            valid;
  logic                            ready;
  logic [eif_pkg::SAMPLE_BITS-1:0] clean_sample;
  logic                            clipped;

  modport source (output valid, output clean_sample, output clipped, input ready);
  modport sink   (input valid, input clean_sample, input clipped, output ready);
endinterface
`default_nettype wire

// ===== hdl/ecg_iir_filter_chain.sv =====
`default_nettype none
// ECG conditioning chain: DC-blocking high-pass, biquad notch, one-pole low-pass,
// then a mid-scale offset and a clamp to the 12-bit sample range.
// Channels: in_ch carries one raw converter sample per request (valid/ready);
// out_ch returns one filtered sample and a clip flag per request, in order.
// cfg_we/cfg_index/cfg_data write the coefficient and offset registers; write
// them only while no request is in flight.
// One request at a time: the next request is taken only once the core has handed
// its result to the output register. Six products run through one serial
// multiplier that takes the coefficient one bit per cycle; three stand-alone
// saturating adds and an output step complete the sequence.
// The output register holds a finished result, so the next request is taken
// while the receiver stalls; only a second result blocks, in the output state.
// Reset (rst_n low, synchronous): registers to their default coefficients,
// all filter history to zero, no result pending.
module ecg_iir_filter_chain #(
  parameter int COEF_FRAC_BITS = eif_pkg::DEF_COEF_FRAC_BITS,
  parameter int SIGNAL_WIDTH   = eif_pkg::DEF_SIGNAL_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  eif_sample_if.sink                         in_ch,
  eif_result_if.source                       out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [eif_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [eif_pkg::COEF_W-1:0]    cfg_data
);

  eif_pkg::eif_cfg_t cfg_r, cfg_nxt;

  logic              res_valid;
  logic              res_ready;
  eif_pkg::eif_res_t res;

  logic              out_valid_r, out_valid_nxt;
  eif_pkg::eif_res_t out_res_r, out_res_nxt;

  // register file; writes beyond the last register are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        eif_pkg::CFG_HP_COEF:    cfg_nxt.highpass_coef = cfg_data;
        eif_pkg::CFG_NOTCH_B1:   cfg_nxt.notch_b1      = cfg_data;
        eif_pkg::CFG_NOTCH_A1:   cfg_nxt.notch_a1      = cfg_data;
        eif_pkg::CFG_NOTCH_A2:   cfg_nxt.notch_a2      = cfg_data;
        eif_pkg::CFG_LP_COEF:    cfg_nxt.lowpass_coef  = cfg_data;
        eif_pkg::CFG_OUT_OFFSET: cfg_nxt.output_offset = cfg_data[eif_pkg::OFFSET_W-1:0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.highpass_coef <= eif_pkg::RST_HP_COEF;
      cfg_r.notch_b1      <= eif_pkg::RST_NOTCH_B1;
      cfg_r.notch_a1      <= eif_pkg::RST_NOTCH_A1;
      cfg_r.notch_a2      <= eif_pkg::RST_NOTCH_A2;
      cfg_r.lowpass_coef  <= eif_pkg::RST_LP_COEF;
      cfg_r.output_offset <= eif_pkg::RST_OFFSET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  eif_core #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .SIGNAL_WIDTH   (SIGNAL_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_sample (in_ch.adc_sample),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register: free, or being drained this cycle
  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.clean_sample = out_res_r.clean_sample;
  assign out_ch.clipped      = out_res_r.clipped;

endmodule
`default_nettype wire

// ===== hdl/eif_bit_mul.sv =====
`default_nettype none
// Serial-parallel multiplier: coefficient enters MSB first, one bit per cycle.
module eif_bit_mul #(
  parameter int SIGNAL_WIDTH = eif_pkg::DEF_SIGNAL_WIDTH
) (
  input  wire logic                                            clk,
  input  wire logic                                            rst_n,
  input  wire logic                                            start,
  input  wire logic signed [eif_pkg::COEF_W-1:0]               coef,
  input  wire logic signed [SIGNAL_WIDTH-1:0]                  sig,
  output logic                                                 done,
  output logic signed [SIGNAL_WIDTH+eif_pkg::COEF_W-1:0]       prod
);

  localparam int CB    = eif_pkg::COEF_W;
  localparam int SW    = SIGNAL_WIDTH;
  localparam int PW    = SW + CB;
  localparam int CNT_W = $clog2(CB);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(CB - 1);

  logic [CB-1:0]        coef_sh_r, coef_sh_nxt;
  logic signed [SW-1:0] sig_r, sig_nxt;
  logic signed [PW-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic signed [PW-1:0] addend;

  always_comb begin
    addend = '0;
    if (coef_sh_r[CB-1]) begin
      // sign bit of the coefficient carries negative weight
      addend = (cnt_r == '0) ? -PW'(sig_r) : PW'(sig_r);
    end
  end

  always_comb begin
    coef_sh_nxt = coef_sh_r;
    sig_nxt     = sig_r;
    acc_nxt     = acc_r;
    cnt_nxt     = cnt_r;
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    if (start) begin
      coef_sh_nxt = coef;
      sig_nxt     = sig;
      acc_nxt     = '0;
      cnt_nxt     = '0;
      busy_nxt    = 1'b1;
    end else if (busy_r) begin
      acc_nxt     = (acc_r <<< 1) + addend;
      coef_sh_nxt = coef_sh_r << 1;
      cnt_nxt     = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    coef_sh_r <= coef_sh_nxt;
    sig_r     <= sig_nxt;
    acc_r     <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule
`default_nettype wire

// ===== hdl/eif_core.sv =====
`default_nettype none
// Filter sequencer: history registers, saturating adder, shared serial multiplier.
module eif_core #(
  parameter int COEF_FRAC_BITS = eif_pkg::DEF_COEF_FRAC_BITS,
  parameter int SIGNAL_WIDTH   = eif_pkg::DEF_SIGNAL_WIDTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire eif_pkg::eif_cfg_t               cfg,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [eif_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                                 res_valid,
  input  wire logic                            res_ready,
  output eif_pkg::eif_res_t                    res
);

  localparam int F    = COEF_FRAC_BITS;
  localparam int SW   = SIGNAL_WIDTH;
  localparam int CB   = eif_pkg::COEF_W;
  localparam int SB   = eif_pkg::SAMPLE_BITS;
  localparam int PW   = SW + CB;
  localparam int TPW  = PW - F;
  localparam int AW   = ((SW > TPW) ? SW : TPW) + 2;
  localparam int XW   = SB + F;
  localparam int CW   = ((XW > SW) ? XW : SW) + 1;
  localparam int OW   = ((SW > XW) ? SW : XW) + 2;

  localparam logic signed [SW-1:0] SIG_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SIG_MIN = {1'b1, {(SW-1){1'b0}}};

  function automatic logic signed [SW-1:0] sat(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] hi;
    logic signed [AW-1:0] lo;
    hi = AW'(SIG_MAX);
    lo = AW'(SIG_MIN);
    if (v > hi) begin
      sat = SIG_MAX;
    end else if (v < lo) begin
      sat = SIG_MIN;
    end else begin
      sat = v[SW-1:0];
    end
  endfunction

  // raw sample scaled to the signal format, saturating if it does not fit
  function automatic logic signed [SW-1:0] to_sig(input logic [SB-1:0] raw);
    logic [CW-1:0] w;
    logic [CW-1:0] lim;
    w   = CW'(raw) << F;
    lim = CW'(SIG_MAX);
    if (w > lim) begin
      to_sig = SIG_MAX;
    end else begin
      to_sig = w[SW-1:0];
    end
  endfunction

  eif_pkg::eif_state_t state_r, state_nxt;
  logic                launched_r, launched_nxt;

  logic [SB-1:0]        raw_r, raw_nxt;
  logic [SB-1:0]        hp_prev_in_r, hp_prev_in_nxt;
  logic signed [SW-1:0] acc_r, acc_nxt;
  logic signed [SW-1:0] hp_prev_out_r, hp_prev_out_nxt;
  logic signed [SW-1:0] nin0_r, nin0_nxt, nin1_r, nin1_nxt;
  logic signed [SW-1:0] nout0_r, nout0_nxt, nout1_r, nout1_nxt;
  logic signed [SW-1:0] lp_prev_r, lp_prev_nxt;

  logic                 is_mul;
  logic                 mul_start;
  logic                 mul_done;
  logic signed [CB-1:0] mul_coef;
  logic signed [SW-1:0] mul_sig;
  logic signed [PW-1:0] mul_prod;
  logic signed [PW-1:0] prod_neg;
  logic signed [TPW-1:0] prod_t;
  logic signed [TPW-1:0] prod_neg_t;

  logic signed [AW-1:0] alu_a, alu_b;
  logic signed [AW-1:0] alu_sum;
  logic signed [SW-1:0] alu_y;

  logic signed [OW-1:0] total;
  logic signed [OW-1:0] off_w;
  logic signed [OW-1:0] top_w;

  eif_bit_mul #(
    .SIGNAL_WIDTH (SIGNAL_WIDTH)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .coef  (mul_coef),
    .sig   (mul_sig),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // product truncated toward minus infinity, and the negated product likewise
  assign prod_neg   = -mul_prod;
  assign prod_t     = mul_prod[PW-1:F];
  assign prod_neg_t = prod_neg[PW-1:F];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      eif_pkg::ST_IDLE:   if (in_valid) state_nxt = eif_pkg::ST_HP_ADD;
      eif_pkg::ST_HP_ADD: state_nxt = eif_pkg::ST_HP_SUB;
      eif_pkg::ST_HP_SUB: state_nxt = eif_pkg::ST_M_HP;
      eif_pkg::ST_M_HP:   if (mul_done) state_nxt = eif_pkg::ST_M_B1;
      eif_pkg::ST_M_B1:   if (mul_done) state_nxt = eif_pkg::ST_ADD_X2;
      eif_pkg::ST_ADD_X2: state_nxt = eif_pkg::ST_M_A1;
      eif_pkg::ST_M_A1:   if (mul_done) state_nxt = eif_pkg::ST_M_A2;
      eif_pkg::ST_M_A2:   if (mul_done) state_nxt = eif_pkg::ST_M_LPA;
      eif_pkg::ST_M_LPA:  if (mul_done) state_nxt = eif_pkg::ST_M_LPB;
      eif_pkg::ST_M_LPB:  if (mul_done) state_nxt = eif_pkg::ST_OUT;
      eif_pkg::ST_OUT:    if (res_ready) state_nxt = eif_pkg::ST_IDLE;
      default:            state_nxt = eif_pkg::ST_IDLE;
    endcase
  end

  // control outputs and operand selection
  always_comb begin
    in_ready  = (state_r == eif_pkg::ST_IDLE);
    res_valid = (state_r == eif_pkg::ST_OUT);
    is_mul    = 1'b0;
    mul_coef  = cfg.lowpass_coef;
    mul_sig   = lp_prev_r;
    alu_a     = '0;
    alu_b     = '0;
    unique case (state_r)
      eif_pkg::ST_HP_ADD: begin
        alu_a = AW'(hp_prev_out_r);
        alu_b = AW'(to_sig(raw_r));
      end
      eif_pkg::ST_HP_SUB: begin
        alu_a = AW'(acc_r);
        alu_b = -AW'(to_sig(hp_prev_in_r));
      end
      eif_pkg::ST_M_HP: begin
        is_mul   = 1'b1;
        mul_coef = cfg.highpass_coef;
        mul_sig  = acc_r;
        alu_b    = AW'(prod_t);
      end
      eif_pkg::ST_M_B1: begin
        is_mul   = 1'b1;
        mul_coef = cfg.notch_b1;
        mul_sig  = nin0_r;
        alu_a    = AW'(hp_prev_out_r);
        alu_b    = AW'(prod_t);
      end
      eif_pkg::ST_ADD_X2: begin
        alu_a = AW'(acc_r);
        alu_b = AW'(nin1_r);
      end
      eif_pkg::ST_M_A1: begin
        is_mul   = 1'b1;
        mul_coef = cfg.notch_a1;
        mul_sig  = nout0_r;
        alu_a    = AW'(acc_r);
        alu_b    = -AW'(prod_t);
      end
      eif_pkg::ST_M_A2: begin
        is_mul   = 1'b1;
        mul_coef = cfg.notch_a2;
        mul_sig  = nout1_r;
        alu_a    = AW'(acc_r);
        alu_b    = -AW'(prod_t);
      end
      eif_pkg::ST_M_LPA: begin
        is_mul   = 1'b1;
        mul_coef = cfg.lowpass_coef;
        mul_sig  = nout0_r;
        alu_a    = AW'(lp_prev_r);
        alu_b    = AW'(prod_t);
      end
      eif_pkg::ST_M_LPB: begin
        // (1-a)*y1 as y1 + floor(-a*y1), y1 already summed in acc
        is_mul   = 1'b1;
        mul_coef = cfg.lowpass_coef;
        mul_sig  = lp_prev_r;
        alu_a    = AW'(acc_r);
        alu_b    = AW'(prod_neg_t);
      end
      default: begin
        alu_a = '0;
      end
    endcase
    mul_start = is_mul && !launched_r;
  end

  assign alu_sum = alu_a + alu_b;
  assign alu_y   = sat(alu_sum);

  // datapath register updates
  always_comb begin
    raw_nxt         = raw_r;
    hp_prev_in_nxt  = hp_prev_in_r;
    acc_nxt         = acc_r;
    hp_prev_out_nxt = hp_prev_out_r;
    nin0_nxt        = nin0_r;
    nin1_nxt        = nin1_r;
    nout0_nxt       = nout0_r;
    nout1_nxt       = nout1_r;
    lp_prev_nxt     = lp_prev_r;
    launched_nxt    = launched_r;
    if (is_mul) begin
      if (mul_done) begin
        launched_nxt = 1'b0;
      end else if (!launched_r) begin
        launched_nxt = 1'b1;
      end
    end
    case (state_r) inside
      eif_pkg::ST_IDLE: begin
        if (in_valid) raw_nxt = in_sample;
      end
      eif_pkg::ST_HP_ADD, eif_pkg::ST_ADD_X2: begin
        acc_nxt = alu_y;
      end
      eif_pkg::ST_HP_SUB: begin
        acc_nxt        = alu_y;
        hp_prev_in_nxt = raw_r;
      end
      eif_pkg::ST_M_HP: begin
        if (mul_done) begin
          acc_nxt         = alu_y;
          hp_prev_out_nxt = alu_y;
        end
      end
      eif_pkg::ST_M_B1, eif_pkg::ST_M_A1, eif_pkg::ST_M_LPA: begin
        if (mul_done) acc_nxt = alu_y;
      end
      eif_pkg::ST_M_A2: begin
        if (mul_done) begin
          acc_nxt   = alu_y;
          nout0_nxt = alu_y;
          nout1_nxt = nout0_r;
          nin0_nxt  = hp_prev_out_r;
          nin1_nxt  = nin0_r;
        end
      end
      eif_pkg::ST_M_LPB: begin
        if (mul_done) begin
          acc_nxt     = alu_y;
          lp_prev_nxt = alu_y;
        end
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase
  end

  // offset, clamp and truncate
  always_comb begin
    off_w = signed'(OW'(cfg.output_offset) << F);
    top_w = signed'(OW'(eif_pkg::SAMPLE_MAX) << F);
    total = OW'(lp_prev_r) + off_w;
    if (total < 0) begin
      res.clean_sample = '0;
      res.clipped      = 1'b1;
    end else if (total > top_w) begin
      res.clean_sample = eif_pkg::SAMPLE_MAX;
      res.clipped      = 1'b1;
    end else begin
      res.clean_sample = total[F +: SB];
      res.clipped      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= eif_pkg::ST_IDLE;
      launched_r    <= 1'b0;
      hp_prev_in_r  <= '0;
      hp_prev_out_r <= '0;
      nin0_r        <= '0;
      nin1_r        <= '0;
      nout0_r       <= '0;
      nout1_r       <= '0;
      lp_prev_r     <= '0;
    end else begin
      state_r       <= state_nxt;
      launched_r    <= launched_nxt;
      hp_prev_in_r  <= hp_prev_in_nxt;
      hp_prev_out_r <= hp_prev_out_nxt;
      nin0_r        <= nin0_nxt;
      nin1_r        <= nin1_nxt;
      nout0_r       <= nout0_nxt;
      nout1_r       <= nout1_nxt;
      lp_prev_r     <= lp_prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    raw_r <= raw_nxt;
    acc_r <= acc_nxt;
  end

endmodule
`default_nettype wire

// ===== hdl/eif_checker.sv =====
`default_nettype none
module eif_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [eif_pkg::SAMPLE_BITS-1:0] clean_sample,
  input wire logic                            clipped
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(clean_sample) && $stable(clipped))
    else $error("result changed while stalled");

  // one request at a time
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // a result cannot appear right after a request is taken
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result too early");

  // clip flag only at the range ends
  a_clip_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && clipped |->
      clean_sample == '0 || clean_sample == eif_pkg::SAMPLE_MAX)
    else $error("clip flag inside range");

endmodule

bind ecg_iir_filter_chain eif_checker u_eif_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .clean_sample (out_ch.clean_sample),
  .clipped      (out_ch.clipped)
);
`default_nettype wire
